FILE: rtl/beab_pkg.sv
// Shared types, codes and the alpha table for the bitmap edge alpha blur block.
package beab_pkg;

    localparam int DEF_WIDTH  = 256;
    localparam int DEF_HEIGHT = 224;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic [3:0] ALPHA_NONE  = 4'h0;
    localparam logic [3:0] ALPHA_CLEAR = 4'hf;
    localparam logic [3:0] ALPHA_FEW   = 4'hd;
    localparam logic [3:0] ALPHA_SOME  = 4'hc;
    localparam logic [3:0] ALPHA_HALF  = 4'hb;
    localparam logic [3:0] ALPHA_MOST  = 4'h9;
    localparam logic [3:0] ALPHA_FULL  = 4'h5;

    typedef struct packed {
        logic       cmd;
        logic [7:0] row;
        logic [4:0] byte_index;
        logic [7:0] pixel_col;
        logic [7:0] data;
    } t_in;

    typedef struct packed {
        logic [3:0] pixel_value;
        logic       lit;
    } t_out;

    // One access to the two-bank frame store. On reads, byte_idx is the byte of
    // the pixel and lo selects the byte pair that starts one byte lower.
    typedef struct packed {
        logic       wr;
        logic       rd;
        logic [7:0] row;
        logic [4:0] byte_idx;
        logic       lo;
        logic [7:0] data;
    } t_mem_req;

    function automatic logic [3:0] alpha_of(input logic [3:0] lit_count);
        logic [3:0] a;
        case (lit_count) inside
            4'd0:          a = ALPHA_CLEAR;
            [4'd1:4'd2]:   a = ALPHA_FEW;
            [4'd3:4'd4]:   a = ALPHA_SOME;
            [4'd5:4'd6]:   a = ALPHA_HALF;
            4'd7:          a = ALPHA_MOST;
            default:       a = ALPHA_FULL;
        endcase
        return a;
    endfunction

endpackage

FILE: rtl/bitmap_edge_alpha_blur.sv
// Top level: request handshake, three-row neighbor scan and result register.
//
// A one-bit-per-pixel frame of HEIGHT rows by WIDTH pixels lives in two byte
// banks (even and odd bytes of a row), so a pixel and both its horizontal
// neighbors come out of one access. A write request returns a zero result.
// A pixel read fetches one frame row per bank access (row above, own row, row
// below), set by the single read port of each bank; a new read can enter while
// the last one's result is stored. A read outside the frame answers with
// zeros. The frame is not cleared at reset: read only pixels whose bytes and
// neighbor bytes have been written. A finished result waits in an output
// register while the next request enters.
module bitmap_edge_alpha_blur #(
    parameter int WIDTH  = beab_pkg::DEF_WIDTH,
    parameter int HEIGHT = beab_pkg::DEF_HEIGHT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  beab_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output beab_pkg::t_out o_out_data
);
    import beab_pkg::*;

    localparam int ROW_BYTES = (WIDTH + 7) / 8;

    typedef enum logic [1:0] {S_IDLE, S_MID, S_BOT, S_LAST} t_state;

    t_state     r_state;
    logic [7:0] r_row;
    logic [7:0] r_col;
    logic [3:0] r_cnt;
    logic       r_self;
    t_out       r_out;
    logic       r_out_valid;

    logic       out_ready;
    logic       in_imm;
    logic       in_wr_ok;
    logic       can_accept;
    logic       accept;
    logic       top_ok;
    logic       bot_ok;
    logic       left_ok;
    logic       right_ok;
    logic [15:0] window;
    logic [3:0] pos;
    logic       bit_l;
    logic       bit_m;
    logic       bit_r;
    logic [3:0] n_total;
    t_mem_req   mem_req;

    beab_frame #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_frame (
        .i_clk    (i_clk),
        .i_req    (mem_req),
        .o_window (window)
    );

    assign out_ready = !r_out_valid || !i_out_stall;

    // Writes and reads outside the frame answer at once with a zero result.
    assign in_imm = (i_in_data.cmd == CMD_WRITE)
                 || (32'(i_in_data.row) >= HEIGHT)
                 || (32'(i_in_data.pixel_col) >= WIDTH);
    assign in_wr_ok = (i_in_data.cmd == CMD_WRITE)
                   && (32'(i_in_data.row) < HEIGHT)
                   && (32'(i_in_data.byte_index) < ROW_BYTES);

    assign can_accept = ((r_state == S_IDLE) && (!in_imm || out_ready))
                     || ((r_state == S_LAST) && out_ready && !in_imm);
    assign o_in_stall = !can_accept;
    assign accept     = i_in_valid && can_accept;

    assign top_ok   = (r_row != 8'd0);
    assign bot_ok   = (32'(r_row) + 32'd1) < HEIGHT;
    assign left_ok  = (r_col != 8'd0);
    assign right_ok = (32'(r_col) + 32'd1) < WIDTH;

    // Pixel sits at bit 8..11 of the window when the pair starts a byte lower.
    assign pos   = {~r_col[2], r_col[2:0]};
    assign bit_l = window[pos - 4'd1] & left_ok;
    assign bit_m = window[pos];
    assign bit_r = window[pos + 4'd1] & right_ok;

    assign n_total = r_cnt + (bot_ok ? 4'(bit_l) + 4'(bit_m) + 4'(bit_r) : 4'd0);

    // Reads and writes never share a cycle: writes enter only from idle.
    always_comb begin
        mem_req      = '0;
        mem_req.data = i_in_data.data;
        if (accept) begin
            mem_req.wr = in_wr_ok;
            mem_req.rd = (i_in_data.cmd == CMD_READ) && !in_imm && (i_in_data.row != 8'd0);
            if (i_in_data.cmd == CMD_WRITE) begin
                mem_req.row      = i_in_data.row;
                mem_req.byte_idx = i_in_data.byte_index;
            end else begin
                mem_req.row      = i_in_data.row - 8'd1;
                mem_req.byte_idx = i_in_data.pixel_col[7:3];
            end
            mem_req.lo = ~i_in_data.pixel_col[2];
        end else begin
            mem_req.rd       = (r_state == S_MID) || ((r_state == S_BOT) && bot_ok);
            mem_req.row      = (r_state == S_MID) ? r_row : r_row + 8'd1;
            mem_req.byte_idx = r_col[7:3];
            mem_req.lo       = ~r_col[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_row <= i_in_data.row;
                r_col <= i_in_data.pixel_col;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept && !in_imm) begin
                        r_state <= S_MID;
                    end
                end
                S_MID: begin
                    r_cnt   <= top_ok ? 4'(bit_l) + 4'(bit_m) + 4'(bit_r) : 4'd0;
                    r_state <= S_BOT;
                end
                S_BOT: begin
                    r_cnt   <= r_cnt + 4'(bit_l) + 4'(bit_r);
                    r_self  <= bit_m;
                    r_state <= S_LAST;
                end
                S_LAST: begin
                    // hold until the result register frees up
                    if (out_ready) begin
                        r_state <= accept ? S_MID : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if ((r_state == S_LAST) && out_ready) begin
                r_out_valid       <= 1'b1;
                r_out.lit         <= r_self;
                r_out.pixel_value <= r_self ? ALPHA_NONE : alpha_of(n_total);
            end else if (accept && in_imm) begin
                r_out_valid <= 1'b1;
                r_out       <= '0;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_no_rd_wr_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_req.wr && mem_req.rd))
        else $error("frame read and write in the same cycle");

    a_lit_is_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.lit) |-> (r_out.pixel_value == ALPHA_NONE))
        else $error("lit pixel with nonzero alpha");

    a_partial_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LAST) |-> (r_cnt <= 4'd5))
        else $error("neighbor count too large after two rows");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_LAST) && !out_ready) |=> (r_state == S_LAST))
        else $error("finished read left before its result was stored");

endmodule

FILE: rtl/beab_frame.sv
// Frame store split into even and odd byte banks; reads return a 16-bit pixel window.
module beab_frame #(
    parameter int WIDTH  = beab_pkg::DEF_WIDTH,
    parameter int HEIGHT = beab_pkg::DEF_HEIGHT
) (
    input  logic               i_clk,
    input  beab_pkg::t_mem_req i_req,
    output logic [15:0]        o_window
);
    import beab_pkg::*;

    localparam int ROW_BYTES = (WIDTH + 7) / 8;
    localparam int HALF      = (ROW_BYTES + 1) / 2;
    localparam int DEPTH     = HEIGHT * HALF;
    localparam int AW        = $clog2(DEPTH);

    logic [7:0] r_bank_even [DEPTH];
    logic [7:0] r_bank_odd  [DEPTH];
    logic [7:0] r_rd_even;
    logic [7:0] r_rd_odd;
    logic       r_swap;

    logic [4:0]    half;
    logic [4:0]    half_even;
    logic [4:0]    half_odd;
    logic [AW-1:0] addr_wr;
    logic [AW-1:0] addr_even;
    logic [AW-1:0] addr_odd;

    // Any two adjacent bytes sit in different banks, so one access fetches the pair.
    always_comb begin
        half      = {1'b0, i_req.byte_idx[4:1]};
        half_even = half + {4'd0, ~i_req.lo & i_req.byte_idx[0]};
        half_odd  = (i_req.lo && !i_req.byte_idx[0] && half != 5'd0) ? half - 5'd1 : half;
        addr_wr   = AW'(32'(i_req.row) * HALF + 32'(half));
        addr_even = AW'(32'(i_req.row) * HALF + 32'(half_even));
        addr_odd  = AW'(32'(i_req.row) * HALF + 32'(half_odd));
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            if (i_req.byte_idx[0]) begin
                r_bank_odd[addr_wr] <= i_req.data;
            end else begin
                r_bank_even[addr_wr] <= i_req.data;
            end
        end
        if (i_req.rd) begin
            r_rd_even <= r_bank_even[addr_even];
            r_rd_odd  <= r_bank_odd[addr_odd];
            r_swap    <= i_req.byte_idx[0] ^ i_req.lo;
        end
    end

    // Lower byte of the pair goes to the low half of the window.
    assign o_window = r_swap ? {r_rd_even, r_rd_odd} : {r_rd_odd, r_rd_even};

endmodule
